[rtl/core/ccj_pkg.sv]
// ============================================================================
// ccj_pkg: shared types and constants for the coin/credit joystick I/O chip
// Holds the command codes, the reply bytes and the beat payload structs.
// ============================================================================
package ccj_pkg;

    localparam logic [7:0] CMD_POLL       = 8'h71;
    localparam logic [7:0] CMD_CLEAR      = 8'h91;
    localparam logic [7:0] CMD_PROT_READ  = 8'h74;
    localparam logic [7:0] CMD_PROT_LATCH = 8'h64;

    localparam logic [7:0] STATUS_START   = 8'h7e;
    localparam logic [7:0] STATUS_POLL    = 8'h80;
    localparam logic [7:0] CODE_START_ONE = 8'hff;
    localparam logic [7:0] CODE_START_TWO = 8'hfe;
    localparam logic [7:0] PROT_KEY       = 8'h80;
    localparam logic [7:0] PROT_PASS      = 8'h05;
    localparam logic [7:0] PROT_FAIL      = 8'h95;
    localparam logic [6:0] CREDIT_MAX     = 7'd99;

    localparam logic [3:0] MASK_NONE      = 4'h0;
    localparam logic [3:0] MASK_PLAYER    = 4'h7;
    localparam logic [3:0] MASK_ALL       = 4'hf;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] switch_port_a;
        logic [7:0] switch_port_b;
        logic [7:0] shared_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] player_one_byte;
        logic [7:0] player_two_byte;
        logic [7:0] protect_byte;
        logic [3:0] write_mask;
    } out_item_t;

    // Direction code from active-high {up, down, left, right}.
    // Up wins over down and right wins over left; 8 means centered.
    function automatic logic [3:0] dir_code(input logic [3:0] act);
        logic [3:0] code;
        case (act)
            4'h0:    code = 4'd8;
            4'h1:    code = 4'd2;
            4'h2:    code = 4'd6;
            4'h3:    code = 4'd2;
            4'h4:    code = 4'd4;
            4'h5:    code = 4'd3;
            4'h6:    code = 4'd5;
            4'h7:    code = 4'd3;
            4'h8:    code = 4'd0;
            4'h9:    code = 4'd1;
            4'ha:    code = 4'd7;
            4'hb:    code = 4'd1;
            4'hc:    code = 4'd0;
            4'hd:    code = 4'd1;
            4'he:    code = 4'd7;
            default: code = 4'd1;
        endcase
        return code;
    endfunction

    // Joystick byte: fire bits pass through as active-low levels.
    function automatic logic [7:0] joystick_byte(input logic [7:0] port);
        logic [3:0] act;
        act = ~port[3:0];
        return {2'b11, port[5], port[4], dir_code(act)};
    endfunction

endpackage

[rtl/core/ccj_if.sv]
// ============================================================================
// ccj_if: valid/ready channels of the coin/credit joystick I/O chip
// One interface for command beats and one for reply beats.
// ============================================================================
interface ccj_in_if
    import ccj_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ccj_out_if
    import ccj_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/coin_credit_joystick_io_chip.sv]
// ============================================================================
// coin_credit_joystick_io_chip: command handler of a custom I/O chip
// Counts coins, spends credits on start presses, reports the joystick and
// answers the protection check, one reply beat for each command beat.
// ============================================================================
//
//   channel   dir   beat payload
//   -------   ---   ------------------------------------------------------
//   in_ch     in    command, switch_port_a, switch_port_b, shared_byte
//   out_ch    out   status_byte, player_one/two_byte, protect_byte, mask
//
// A command beat is accepted in any cycle in which the reply register is
// empty or being drained, so one beat per cycle flows through when the
// consumer keeps up. The reply is registered and appears in the cycle after its command is taken.
// Reset clears the credit count, the held flags, the protection byte and
// the reply valid flag. A stalled reply holds its register and blocks input.
//
module coin_credit_joystick_io_chip
    import ccj_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ccj_in_if.sink          in_ch,
    ccj_out_if.source       out_ch
);

    logic [6:0] credit_reg;
    logic [6:0] credit_next;
    logic       coin_held_reg;
    logic       coin_held_next;
    logic       start_one_held_reg;
    logic       start_one_held_next;
    logic       start_two_held_reg;
    logic       start_two_held_next;
    logic [7:0] prot_reg;
    logic [7:0] prot_next;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    logic       accept;
    logic [6:0] credit_coin;
    logic [6:0] credit_one;
    logic       take_one;
    logic       take_two;
    logic       coin_press;
    logic       one_press;
    logic       two_press;
    logic [7:0] player_byte;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_comb
    begin
        coin_press = !in_ch.data.switch_port_a[4];
        one_press  = !in_ch.data.switch_port_a[0];
        two_press  = !in_ch.data.switch_port_a[1];

        credit_coin = credit_reg;
        if (coin_press && !coin_held_reg && (credit_reg < CREDIT_MAX))
        begin
            credit_coin = credit_reg + 7'd1;
        end

        take_one   = one_press && !start_one_held_reg && (credit_coin >= 7'd1);
        credit_one = take_one ? credit_coin - 7'd1 : credit_coin;
        take_two   = two_press && !start_two_held_reg && (credit_one >= 7'd2);

        credit_next         = credit_reg;
        coin_held_next      = coin_held_reg;
        start_one_held_next = start_one_held_reg;
        start_two_held_next = start_two_held_reg;
        prot_next           = prot_reg;
        out_data_next       = '0;

        if (take_two)
        begin
            player_byte = CODE_START_TWO;
        end
        else if (take_one)
        begin
            player_byte = CODE_START_ONE;
        end
        else
        begin
            player_byte = joystick_byte(in_ch.data.switch_port_b);
        end

        case (in_ch.data.command)
            CMD_POLL:
            begin
                credit_next         = take_two ? credit_one - 7'd2 : credit_one;
                coin_held_next      = coin_press;
                start_one_held_next = one_press;
                start_two_held_next = two_press;
                out_data_next.status_byte     = (take_one || take_two) ?
                                                STATUS_START : STATUS_POLL;
                out_data_next.player_one_byte = player_byte;
                out_data_next.player_two_byte = player_byte;
                out_data_next.write_mask      = MASK_PLAYER;
            end
            CMD_CLEAR:
            begin
                out_data_next.write_mask = MASK_PLAYER;
            end
            CMD_PROT_READ:
            begin
                out_data_next.protect_byte = (prot_reg == PROT_KEY) ?
                                             PROT_PASS : PROT_FAIL;
                out_data_next.write_mask   = MASK_ALL;
            end
            CMD_PROT_LATCH:
            begin
                prot_next = in_ch.data.shared_byte;
            end
            default:
            begin
                out_data_next.write_mask = MASK_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg         <= '0;
            coin_held_reg      <= 1'b0;
            start_one_held_reg <= 1'b0;
            start_two_held_reg <= 1'b0;
            prot_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                credit_reg         <= credit_next;
                coin_held_reg      <= coin_held_next;
                start_one_held_reg <= start_one_held_next;
                start_two_held_reg <= start_two_held_next;
                prot_reg           <= prot_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[sim/tb_coin_credit_joystick_io_chip.sv]
// ============================================================================
// tb_coin_credit_joystick_io_chip: self-checking bench for the I/O chip
// Sends command beats with random gaps while the reply side stalls at random
// (not in the steady-flow run), predicts each reply from a local copy of the
// credit, held-flag and protection state, checks each beat field by field in order.
// ============================================================================
module tb_coin_credit_joystick_io_chip;
    import ccj_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [7:0] CMD_NOP      = 8'h00;
    localparam logic [7:0] SW_RELEASED  = 8'hff;
    localparam logic [7:0] PA_COIN      = 8'hef;
    localparam logic [7:0] PA_START_ONE = 8'hfe;
    localparam logic [7:0] PA_START_TWO = 8'hfd;
    localparam logic [7:0] PA_STARTS    = 8'hfc;

    localparam int COIN_BIT      = 4;
    localparam int START_ONE_BIT = 0;
    localparam int START_TWO_BIT = 1;
    localparam int RIGHT_BIT     = 0;
    localparam int LEFT_BIT      = 1;
    localparam int DOWN_BIT      = 2;
    localparam int UP_BIT        = 3;

    logic clk;
    logic rst_n;

    ccj_in_if  in_ch ();
    ccj_out_if out_ch ();

    coin_credit_joystick_io_chip dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [6:0] credits;
    logic       coin_down;
    logic       start_one_down;
    logic       start_two_down;
    logic [7:0] latched_key;

    out_item_t pending_replies[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        steady_flow;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] stick_byte(input logic [7:0] port);
        logic       up;
        logic       down;
        logic       left;
        logic       right;
        logic [3:0] dir;
        up    = !port[UP_BIT];
        down  = !port[DOWN_BIT];
        left  = !port[LEFT_BIT];
        right = !port[RIGHT_BIT];
        if (up)
            dir = right ? 4'd1 : (left ? 4'd7 : 4'd0);
        else if (down)
            dir = right ? 4'd3 : (left ? 4'd5 : 4'd4);
        else
            dir = right ? 4'd2 : (left ? 4'd6 : 4'd8);
        return {2'b11, port[5], port[4], dir};
    endfunction

    function automatic out_item_t predict_reply(input in_item_t item);
        out_item_t  reply;
        logic [7:0] code;
        reply = '0;
        code  = 8'h00;
        if (item.command == CMD_POLL)
        begin
            if (!item.switch_port_a[COIN_BIT])
            begin
                if (!coin_down && credits < CREDIT_MAX)
                    credits = credits + 7'd1;
                coin_down = 1'b1;
            end
            else
                coin_down = 1'b0;
            if (!item.switch_port_a[START_ONE_BIT])
            begin
                if (!start_one_down && credits >= 7'd1)
                begin
                    credits = credits - 7'd1;
                    code = CODE_START_ONE;
                end
                start_one_down = 1'b1;
            end
            else
                start_one_down = 1'b0;
            if (!item.switch_port_a[START_TWO_BIT])
            begin
                if (!start_two_down && credits >= 7'd2)
                begin
                    credits = credits - 7'd2;
                    code = CODE_START_TWO;
                end
                start_two_down = 1'b1;
            end
            else
                start_two_down = 1'b0;
            if (code != 8'h00)
            begin
                reply.status_byte     = STATUS_START;
                reply.player_one_byte = code;
            end
            else
            begin
                reply.status_byte     = STATUS_POLL;
                reply.player_one_byte = stick_byte(item.switch_port_b);
            end
            reply.player_two_byte = reply.player_one_byte;
            reply.write_mask      = MASK_PLAYER;
        end
        else if (item.command == CMD_CLEAR)
            reply.write_mask = MASK_PLAYER;
        else if (item.command == CMD_PROT_READ)
        begin
            reply.protect_byte = (latched_key == PROT_KEY) ? PROT_PASS : PROT_FAIL;
            reply.write_mask   = MASK_ALL;
        end
        else if (item.command == CMD_PROT_LATCH)
            latched_key = item.shared_byte;
        return reply;
    endfunction

    function automatic in_item_t build_item(input logic [7:0] command, input logic [7:0] port_a,
                                            input logic [7:0] port_b, input logic [7:0] shared);
        in_item_t item;
        item.command       = command;
        item.switch_port_a = port_a;
        item.switch_port_b = port_b;
        item.shared_byte   = shared;
        return item;
    endfunction

    task automatic send_command(input in_item_t item);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_replies.push_back(predict_reply(item));
    endtask

    task automatic drain_replies();
        in_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (pending_replies.size() == 0)
        begin
            $error("reply beat with no command waiting: %h", got);
            mismatch_count++;
            return;
        end
        want = pending_replies.pop_front();
        if (got.status_byte !== want.status_byte)
        begin
            $error("status_byte: expected %h, got %h", want.status_byte, got.status_byte);
            mismatch_count++;
        end
        if (got.player_one_byte !== want.player_one_byte)
        begin
            $error("player_one_byte: expected %h, got %h",
                   want.player_one_byte, got.player_one_byte);
            mismatch_count++;
        end
        if (got.player_two_byte !== want.player_two_byte)
        begin
            $error("player_two_byte: expected %h, got %h",
                   want.player_two_byte, got.player_two_byte);
            mismatch_count++;
        end
        if (got.protect_byte !== want.protect_byte)
        begin
            $error("protect_byte: expected %h, got %h", want.protect_byte, got.protect_byte);
            mismatch_count++;
        end
        if (got.write_mask !== want.write_mask)
        begin
            $error("write_mask: expected %h, got %h", want.write_mask, got.write_mask);
            mismatch_count++;
        end
    endtask

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            check_reply(out_ch.data);
        end
    end

    function automatic logic [7:0] draw_nop();
        logic [7:0] command;
        do
            command = 8'($urandom);
        while (command == CMD_POLL || command == CMD_CLEAR ||
               command == CMD_PROT_READ || command == CMD_PROT_LATCH);
        return command;
    endfunction

    function automatic logic [7:0] draw_port_a(input int coin_pct, input int start_pct);
        logic [7:0] port;
        port = 8'($urandom);
        port[COIN_BIT]      = !($urandom_range(0, 99) < coin_pct);
        port[START_ONE_BIT] = !($urandom_range(0, 99) < start_pct);
        port[START_TWO_BIT] = !($urandom_range(0, 99) < start_pct);
        return port;
    endfunction

    task automatic test_protection_and_misc();
        send_command(build_item(CMD_PROT_READ, SW_RELEASED, SW_RELEASED, 8'h80));
        send_command(build_item(CMD_PROT_LATCH, SW_RELEASED, SW_RELEASED, PROT_KEY));
        send_command(build_item(CMD_PROT_READ, 8'h00, 8'h00, 8'h00));
        send_command(build_item(CMD_PROT_LATCH, 8'h00, 8'h00, 8'h00));
        send_command(build_item(CMD_PROT_READ, SW_RELEASED, SW_RELEASED, 8'hff));
        send_command(build_item(CMD_PROT_LATCH, SW_RELEASED, SW_RELEASED, 8'hff));
        send_command(build_item(CMD_PROT_READ, SW_RELEASED, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_CLEAR, PA_STARTS, 8'h00, 8'hff));
        send_command(build_item(CMD_NOP, PA_COIN, 8'h00, 8'h80));
    endtask

    task automatic test_joystick_codes();
        send_command(build_item(CMD_POLL, SW_RELEASED, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, 8'h00, 8'hff));
        send_command(build_item(CMD_POLL, SW_RELEASED, 8'hf3, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, 8'hfc, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, 8'hf9, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, 8'he5, 8'h00));
    endtask

    task automatic test_credit_rules();
        send_command(build_item(CMD_POLL, PA_START_ONE, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, SW_RELEASED, 8'h00));
        repeat (2) send_command(build_item(CMD_POLL, PA_COIN, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, SW_RELEASED, 8'h00));
        repeat (2)
        begin
            send_command(build_item(CMD_POLL, PA_COIN, 8'hf7, 8'h00));
            send_command(build_item(CMD_POLL, SW_RELEASED, 8'hfe, 8'h00));
        end
        send_command(build_item(CMD_POLL, PA_STARTS, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, SW_RELEASED, 8'h00));
    endtask

    task automatic test_credit_limit();
        repeat (105)
        begin
            send_command(build_item(CMD_POLL, PA_COIN, 8'($urandom), 8'($urandom)));
            send_command(build_item(CMD_POLL, SW_RELEASED, 8'($urandom), 8'($urandom)));
        end
        send_command(build_item(CMD_POLL, PA_START_TWO, SW_RELEASED, 8'h00));
        send_command(build_item(CMD_POLL, SW_RELEASED, SW_RELEASED, 8'h00));
    endtask

    task automatic test_random_traffic(input int count, input int coin_pct, input int start_pct);
        in_item_t item;
        int       pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            item = build_item(CMD_POLL, draw_port_a(coin_pct, start_pct),
                              8'($urandom), 8'($urandom));
            if (pick >= 92)
                item.command = draw_nop();
            else if (pick >= 86)
            begin
                item.command = CMD_PROT_LATCH;
                if ($urandom_range(0, 1) == 0)
                    item.shared_byte = PROT_KEY;
            end
            else if (pick >= 78)
                item.command = CMD_PROT_READ;
            else if (pick >= 70)
                item.command = CMD_CLEAR;
            send_command(item);
        end
    endtask

    initial
    begin
        credits        = '0;
        coin_down      = 1'b0;
        start_one_down = 1'b0;
        start_two_down = 1'b0;
        latched_key    = '0;
        steady_flow    = 1'b0;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_protection_and_misc();
        test_joystick_codes();
        test_credit_rules();
        drain_replies();
        test_credit_limit();
        drain_replies();
        test_random_traffic(380, 60, 10);
        drain_replies();
        steady_flow = 1'b1;
        test_random_traffic(380, 30, 40);
        drain_replies();
        steady_flow = 1'b0;
        test_random_traffic(380, 50, 50);
        drain_replies();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
